@@ hw/rtl/vcpd_pkg.sv @@
// Shared types, constants and codes for the CLUT pixel decoder.
package vcpd_pkg;

    // Colour lookup tables
    localparam int TABLE_DEPTH = 32;
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);

    // Queue between front and back (depth must be a power of two)
    localparam int Q_DEPTH = 4;
    localparam int QIDX_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Field widths
    localparam int PIX_W  = 16;
    localparam int COMP_W = 5;
    localparam int CHAN_W = 8;
    localparam int RGB_W  = 3 * CHAN_W;
    localparam int CFG_W  = RGB_W;

    // Input item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // Table select codes
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BACKGROUND = 2'd0;
    localparam logic [1:0] CFG_BYPASS     = 2'd1;
    localparam logic [1:0] CFG_BLUE_LSB   = 2'd2;
    localparam logic [1:0] CFG_BLEND      = 2'd3;

    // Request kinds carried through the queue
    localparam logic [1:0] KIND_PIXEL    = 2'd0;
    localparam logic [1:0] KIND_WR_RED   = 2'd1;
    localparam logic [1:0] KIND_WR_GREEN = 2'd2;
    localparam logic [1:0] KIND_WR_BLUE  = 2'd3;

    // Pixel decode classes
    localparam logic [1:0] CLS_BACKGROUND = 2'd0;
    localparam logic [1:0] CLS_BYPASS     = 2'd1;
    localparam logic [1:0] CLS_TABLE      = 2'd2;

    typedef struct packed {
        logic [RGB_W-1:0] background_rgb;
        logic             bypass_enable;
        logic             blue_lsb_enable;
        logic             blend_enable;
    } t_cfg;

    // One queued request; a table write packs index and value into pix_a
    typedef struct packed {
        logic [1:0]       kind;
        logic [PIX_W-1:0] pix_a;
        logic [PIX_W-1:0] pix_b;
        logic [1:0]       cls_a;
        logic [1:0]       cls_b;
        logic             blend;
    } t_qentry;

endpackage

@@ hw/rtl/vcpd_front.sv @@
// Front end: accepts requests and classifies them for the back end.
module vcpd_front (
    input  logic                            i_valid,
    input  logic                            i_mode,
    input  logic [1:0]                      i_table_select,
    input  logic [vcpd_pkg::TIDX_W-1:0]     i_table_index,
    input  logic [vcpd_pkg::CHAN_W-1:0]     i_table_value,
    input  logic [vcpd_pkg::PIX_W-1:0]      i_pixel,
    input  logic [vcpd_pkg::PIX_W-1:0]      i_current_pixel,
    input  vcpd_pkg::t_cfg                  i_cfg,
    input  logic                            i_full,
    output logic                            o_stall,
    output logic                            o_push,
    output vcpd_pkg::t_qentry               o_entry
);
    import vcpd_pkg::*;

    localparam int WPAD_W = PIX_W - TIDX_W - CHAN_W;

    function automatic logic [1:0] classify(input logic [PIX_W-1:0] px, input logic byp);
        logic [1:0] c;
        if (px[PIX_W-2:0] == '0) begin
            c = CLS_BACKGROUND;
        end else if (byp && px[PIX_W-1]) begin
            c = CLS_BYPASS;
        end else begin
            c = CLS_TABLE;
        end
        return c;
    endfunction

    logic accept;
    logic drop;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Build the queue entry; a write to table select three is dropped
    always_comb begin
        drop           = 1'b0;
        o_entry.pix_a  = i_pixel;
        o_entry.pix_b  = i_current_pixel;
        o_entry.cls_a  = classify(i_pixel, i_cfg.bypass_enable);
        o_entry.cls_b  = classify(i_current_pixel, i_cfg.bypass_enable);
        o_entry.blend  = i_cfg.blend_enable && (i_current_pixel != i_pixel);
        o_entry.kind   = KIND_PIXEL;
        if (i_mode == MODE_WRITE) begin
            o_entry.pix_a = {{WPAD_W{1'b0}}, i_table_index, i_table_value};
            case (i_table_select)
                SEL_RED:   o_entry.kind = KIND_WR_RED;
                SEL_GREEN: o_entry.kind = KIND_WR_GREEN;
                SEL_BLUE:  o_entry.kind = KIND_WR_BLUE;
                default:   drop = 1'b1;
            endcase
        end
    end

    assign o_push = accept && !drop;

endmodule

@@ hw/rtl/vcpd_queue.sv @@
// Short request queue between front and back ends.
module vcpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vcpd_pkg::t_qentry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output vcpd_pkg::t_qentry o_entry
);
    import vcpd_pkg::*;

    t_qentry           r_store [Q_DEPTH];
    logic [QIDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QIDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_store[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(Q_DEPTH))
        else $error("queue fill count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

@@ hw/rtl/vcpd_back.sv @@
// Back end: table writes, table reads, pixel decode, blend and output register.
module vcpd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vcpd_pkg::t_cfg                i_cfg,
    input  logic                          i_q_valid,
    input  vcpd_pkg::t_qentry             i_q_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vcpd_pkg::CHAN_W-1:0]   o_red,
    output logic [vcpd_pkg::CHAN_W-1:0]   o_green,
    output logic [vcpd_pkg::CHAN_W-1:0]   o_blue
);
    import vcpd_pkg::*;

    // Colour tables, one write and two registered reads each
    logic [CHAN_W-1:0] r_red_tab   [TABLE_DEPTH];
    logic [CHAN_W-1:0] r_green_tab [TABLE_DEPTH];
    logic [CHAN_W-1:0] r_blue_tab  [TABLE_DEPTH];

    logic [CHAN_W-1:0] r_rd_red_a, r_rd_green_a, r_rd_blue_a;
    logic [CHAN_W-1:0] r_rd_red_b, r_rd_green_b, r_rd_blue_b;

    // Read stage registers
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix_a, r_s1_pix_b;
    logic [1:0]        r_s1_cls_a, r_s1_cls_b;
    logic              r_s1_blend;

    // Output register
    logic              r_o_valid;
    logic [CHAN_W-1:0] r_red, r_green, r_blue;

    logic              advance;
    logic              pop_pixel;
    logic [TIDX_W-1:0] wr_idx;
    logic [CHAN_W-1:0] wr_val;
    logic [TIDX_W-1:0] ra_r, ra_g, ra_b, rb_r, rb_g, rb_b;
    logic [RGB_W-1:0]  dec_a, dec_b, n_rgb;

    function automatic logic [CHAN_W-1:0] widen5(input logic [COMP_W-1:0] c);
        return {c, c[COMP_W-1:COMP_W-3]};
    endfunction

    function automatic logic [RGB_W-1:0] decode_px(
        input logic [1:0]        cls,
        input logic [PIX_W-1:0]  px,
        input logic [CHAN_W-1:0] tr,
        input logic [CHAN_W-1:0] tg,
        input logic [CHAN_W-1:0] tb,
        input t_cfg              cfg
    );
        logic [RGB_W-1:0] rgb;
        case (cls)
            CLS_BACKGROUND: rgb = cfg.background_rgb;
            CLS_BYPASS:     rgb = {widen5(px[14:10]), widen5(px[9:5]), widen5(px[4:0])};
            default: begin
                if (cfg.blue_lsb_enable) begin
                    rgb = {tr, tg, tb[CHAN_W-1:1], px[PIX_W-1]};
                end else begin
                    rgb = {tr, tg, tb};
                end
            end
        endcase
        return rgb;
    endfunction

    function automatic logic [CHAN_W-1:0] mean_up(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] s;
        s = {1'b0, a} + {1'b0, b} + (CHAN_W+1)'(1);
        return s[CHAN_W:1];
    endfunction

    // Pipeline moves when the output register is free or being taken
    assign advance   = !r_o_valid || !i_stall;
    assign o_pop     = i_q_valid && advance;
    assign pop_pixel = o_pop && (i_q_entry.kind == KIND_PIXEL);

    assign wr_idx = i_q_entry.pix_a[TIDX_W+CHAN_W-1:CHAN_W];
    assign wr_val = i_q_entry.pix_a[CHAN_W-1:0];
    assign ra_r   = i_q_entry.pix_a[14:10];
    assign ra_g   = i_q_entry.pix_a[9:5];
    assign ra_b   = i_q_entry.pix_a[4:0];
    assign rb_r   = i_q_entry.pix_b[14:10];
    assign rb_g   = i_q_entry.pix_b[9:5];
    assign rb_b   = i_q_entry.pix_b[4:0];

    // Table memories
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_q_entry.kind == KIND_WR_RED)) begin
            r_red_tab[wr_idx] <= wr_val;
        end
        if (advance) begin
            r_rd_red_a <= r_red_tab[ra_r];
            r_rd_red_b <= r_red_tab[rb_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_q_entry.kind == KIND_WR_GREEN)) begin
            r_green_tab[wr_idx] <= wr_val;
        end
        if (advance) begin
            r_rd_green_a <= r_green_tab[ra_g];
            r_rd_green_b <= r_green_tab[rb_g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_q_entry.kind == KIND_WR_BLUE)) begin
            r_blue_tab[wr_idx] <= wr_val;
        end
        if (advance) begin
            r_rd_blue_a <= r_blue_tab[ra_b];
            r_rd_blue_b <= r_blue_tab[rb_b];
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= pop_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_pix_a <= i_q_entry.pix_a;
            r_s1_pix_b <= i_q_entry.pix_b;
            r_s1_cls_a <= i_q_entry.cls_a;
            r_s1_cls_b <= i_q_entry.cls_b;
            r_s1_blend <= i_q_entry.blend;
        end
    end

    // Decode both pixels and blend when asked
    always_comb begin
        dec_a = decode_px(r_s1_cls_a, r_s1_pix_a, r_rd_red_a, r_rd_green_a, r_rd_blue_a, i_cfg);
        dec_b = decode_px(r_s1_cls_b, r_s1_pix_b, r_rd_red_b, r_rd_green_b, r_rd_blue_b, i_cfg);
        if (r_s1_blend) begin
            n_rgb = {mean_up(dec_a[23:16], dec_b[23:16]),
                     mean_up(dec_a[15:8],  dec_b[15:8]),
                     mean_up(dec_a[7:0],   dec_b[7:0])};
        end else begin
            n_rgb = dec_a;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_red   <= n_rgb[23:16];
            r_green <= n_rgb[15:8];
            r_blue  <= n_rgb[7:0];
        end
    end

    assign o_valid = r_o_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_q_entry.kind != KIND_PIXEL) |=> !r_s1_valid)
        else $error("table write produced a decode request");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> (r_s1_valid == $past(r_s1_valid)) && !$past(o_pop))
        else $error("read stage moved or popped while output stalled");

endmodule

@@ hw/rtl/vdl_clut_pixel_decoder_unit.sv @@
// Top level of the CLUT pixel decoder: configuration registers, front, queue, back.
// A pixel request passes through the queue write, then the table read stage, then the
// output register, where its result is presented.
// Throughput: one request per cycle unless the output stalls, set by the back end's queue pops.
// Table writes give no result; each takes one queue entry from the back end.
// Reset clears configuration, queue and valid flags; table contents are undefined until written.
module vdl_clut_pixel_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [vcpd_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [1:0]                    i_table_select,
    input  logic [vcpd_pkg::TIDX_W-1:0]   i_table_index,
    input  logic [vcpd_pkg::CHAN_W-1:0]   i_table_value,
    input  logic [vcpd_pkg::PIX_W-1:0]    i_pixel,
    input  logic [vcpd_pkg::PIX_W-1:0]    i_current_pixel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vcpd_pkg::CHAN_W-1:0]   o_red,
    output logic [vcpd_pkg::CHAN_W-1:0]   o_green,
    output logic [vcpd_pkg::CHAN_W-1:0]   o_blue
);
    import vcpd_pkg::*;

    t_cfg    r_cfg;
    logic    push, pop, q_full, q_valid;
    t_qentry push_entry, head_entry;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BACKGROUND: r_cfg.background_rgb  <= i_cfg_data;
                CFG_BYPASS:     r_cfg.bypass_enable   <= i_cfg_data[0];
                CFG_BLUE_LSB:   r_cfg.blue_lsb_enable <= i_cfg_data[0];
                CFG_BLEND:      r_cfg.blend_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vcpd_front u_front (
        .i_valid         (i_valid),
        .i_mode          (i_mode),
        .i_table_select  (i_table_select),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .i_pixel         (i_pixel),
        .i_current_pixel (i_current_pixel),
        .i_cfg           (r_cfg),
        .i_full          (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    vcpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    vcpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (head_entry),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

endmodule
